FILE: hw/rtl/blpe_pkg.sv
// Package for the bounded list edit unit.
// Holds request and status codes, controller states and the command and status
// structs that pass between the controller and the datapath. Depends on nothing.
package blpe_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KIND_W = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W = 5;

    localparam logic [KIND_W-1:0] K_INS_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] K_INS_POS   = 3'd1;
    localparam logic [KIND_W-1:0] K_INS_BACK  = 3'd2;
    localparam logic [KIND_W-1:0] K_DEL_FRONT = 3'd3;
    localparam logic [KIND_W-1:0] K_DEL_POS   = 3'd4;
    localparam logic [KIND_W-1:0] K_DEL_BACK  = 3'd5;
    localparam logic [KIND_W-1:0] K_READ      = 3'd6;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_EDIT,
        CMD_LOAD,
        CMD_STEP
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic read_last;
    } t_dp_status;

endpackage

FILE: hw/rtl/blpe_ctrl.sv
// Controller state machine of the bounded list edit unit.
// Accepts requests and sequences readouts; drives the datapath through commands.
// Depends on blpe_pkg.
module blpe_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [blpe_pkg::KIND_W-1:0]  i_kind,
    input  blpe_pkg::t_dp_status         i_dp_status,
    output logic                         o_ready,
    output blpe_pkg::t_cmd               o_cmd
);
    import blpe_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_kind == K_READ && !i_dp_status.count_zero) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_dp_status.out_free && i_dp_status.read_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd.op = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                o_ready = i_dp_status.out_free;
                if (accept) begin
                    if (i_kind == K_READ && !i_dp_status.count_zero) begin
                        o_cmd.op = CMD_LOAD;
                    end else begin
                        o_cmd.op = CMD_EDIT;
                    end
                end
            end
            S_READ: begin
                if (i_dp_status.out_free) begin
                    o_cmd.op = CMD_STEP;
                end
            end
            default: o_cmd.op = CMD_NONE;
        endcase
    end

endmodule

FILE: hw/rtl/blpe_dp.sv
// Datapath of the bounded list edit unit.
// Holds the row of list cells, the entry count, the readout counter and the
// result register. Depends on blpe_pkg.
module blpe_dp #(
    parameter int CAPACITY = blpe_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  blpe_pkg::t_cmd                      i_cmd,
    input  logic [blpe_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [blpe_pkg::VALUE_W-1:0] i_value,
    input  logic [blpe_pkg::POS_W-1:0]          i_position,
    input  logic                                i_ready,
    output blpe_pkg::t_dp_status                o_dp_status,
    output logic                                o_valid,
    output logic [1:0]                          o_status,
    output logic signed [blpe_pkg::VALUE_W-1:0] o_entry_value,
    output logic                                o_last
);
    import blpe_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;
    localparam logic [IW-1:0] CAP_E = IW'(CAPACITY);

    logic signed [VALUE_W-1:0] r_cells [CAPACITY];
    logic signed [VALUE_W-1:0] n_cells [CAPACITY];
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [CW-1:0]             r_rem;
    logic [CW-1:0]             n_rem;
    logic                      r_valid;
    logic                      n_valid;
    t_status                   r_status;
    t_status                   n_status;
    logic signed [VALUE_W-1:0] r_entry_value;
    logic signed [VALUE_W-1:0] n_entry_value;
    logic                      r_last;
    logic                      n_last;

    logic [IW-1:0]             cnt_e;
    logic [IW-1:0]             cnt_m1;
    logic [IW-1:0]             pos_e;
    logic [IW-1:0]             at;
    logic                      full;
    logic                      empty;
    logic                      do_ins;
    logic                      do_del;
    logic                      out_free;
    t_status                   edit_status;
    logic                      edit_result;

    assign cnt_e  = IW'(r_count);
    assign cnt_m1 = cnt_e - IW'(1);
    assign pos_e  = IW'(i_position);
    assign full   = (cnt_e >= CAP_E);
    assign empty  = (r_count == '0);
    assign out_free = !r_valid || i_ready;

    assign o_dp_status.out_free   = out_free;
    assign o_dp_status.count_zero = empty;
    assign o_dp_status.read_last  = (r_rem == CW'(1));

    always_comb begin
        do_ins = 1'b0;
        do_del = 1'b0;
        at = '0;
        edit_status = ST_OK;
        edit_result = 1'b1;
        case (i_kind)
            K_INS_FRONT: begin
                if (full) edit_status = ST_FULL;
                else do_ins = 1'b1;
            end
            K_INS_POS: begin
                at = pos_e;
                if (full) edit_status = ST_FULL;
                else if (pos_e < IW'(1) || pos_e > cnt_e) edit_status = ST_RANGE;
                else do_ins = 1'b1;
            end
            K_INS_BACK: begin
                at = cnt_e;
                if (full) edit_status = ST_FULL;
                else do_ins = 1'b1;
            end
            K_DEL_FRONT: begin
                if (empty) edit_status = ST_EMPTY;
                else do_del = 1'b1;
            end
            K_DEL_POS: begin
                at = pos_e;
                if (empty) edit_status = ST_EMPTY;
                else if (pos_e < IW'(1) || pos_e >= cnt_e) edit_status = ST_RANGE;
                else do_del = 1'b1;
            end
            K_DEL_BACK: begin
                at = cnt_m1;
                if (empty) edit_status = ST_EMPTY;
                else do_del = 1'b1;
            end
            K_READ: begin
                edit_status = ST_EMPTY;
            end
            default: begin
                edit_result = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_cells = r_cells;
        n_count = r_count;
        n_rem = r_rem;
        n_valid = r_valid && !i_ready;
        n_status = r_status;
        n_entry_value = r_entry_value;
        n_last = r_last;
        case (i_cmd.op)
            CMD_EDIT: begin
                if (do_ins) begin
                    if (at == '0) n_cells[0] = i_value;
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (IW'(i) == at) n_cells[i] = i_value;
                        else if (IW'(i) > at) n_cells[i] = r_cells[i-1];
                    end
                    n_count = r_count + CW'(1);
                end
                if (do_del) begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (IW'(i) >= at) n_cells[i] = r_cells[i+1];
                    end
                    n_count = r_count - CW'(1);
                end
                if (edit_result) begin
                    n_valid = 1'b1;
                    n_status = edit_status;
                    n_entry_value = '0;
                    n_last = 1'b1;
                end
            end
            CMD_LOAD: begin
                n_rem = r_count;
            end
            CMD_STEP: begin
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    if (IW'(i) == cnt_m1) n_cells[i] = r_cells[0];
                    else n_cells[i] = r_cells[i+1];
                end
                if (cnt_m1 == IW'(CAPACITY - 1)) n_cells[CAPACITY-1] = r_cells[0];
                n_rem = r_rem - CW'(1);
                n_valid = 1'b1;
                n_status = ST_OK;
                n_entry_value = r_cells[0];
                n_last = (r_rem == CW'(1));
            end
            default: begin
                n_rem = r_rem;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rem <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_rem <= n_rem;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
        r_status <= n_status;
        r_entry_value <= n_entry_value;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_entry_value = r_entry_value;
    assign o_last = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_e <= CAP_E)
        else $error("entry count above capacity");

    a_step_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == CMD_STEP |-> r_rem != '0 && r_rem <= r_count)
        else $error("readout step without remaining entries");

    a_step_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == CMD_STEP |=> $stable(r_count))
        else $error("entry count changed during readout");

    a_cmd_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op != CMD_NONE |-> out_free)
        else $error("command issued while result register is held");

endmodule

FILE: hw/rtl/bounded_list_positional_edit_unit.sv
// Every edit request (insert or delete at front, position or back) gives one
// result word with last set. A readout gives one word per list entry, one per
// cycle while the output is not stalled, by rotating the row of list cells
// past the result register; an empty readout gives one word. One request is
// in work at a time, so a readout holds off the next request until its last
// word is given. A result register sits on the output, and a stalled output
// stalls the work. Depends on blpe_pkg, blpe_ctrl and blpe_dp.
module bounded_list_positional_edit_unit #(
    parameter int CAPACITY = blpe_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [blpe_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [blpe_pkg::VALUE_W-1:0] i_value,
    input  logic [blpe_pkg::POS_W-1:0]          i_position,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic signed [blpe_pkg::VALUE_W-1:0] o_entry_value,
    output logic                                o_last
);
    import blpe_pkg::*;

    t_cmd       cmd;
    t_dp_status dp_status;

    blpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_dp_status (dp_status),
        .o_ready     (o_ready),
        .o_cmd       (cmd)
    );

    blpe_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_ready       (i_ready),
        .o_dp_status   (dp_status),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_last        (o_last)
    );

endmodule
